FILE: src/tlfr_pkg.sv
// ============================================================================
// tlfr_pkg
// Shared types and constants for the tagged length frame receiver.
// ============================================================================
package tlfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] TAG_FIRST_RST  = 8'd83;   // 'S'
    localparam logic [BYTE_W-1:0] TAG_SECOND_RST = 8'd84;   // 'T'
    localparam logic [WORD_W-1:0] MAX_LEN_RST    = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAG_FIRST  = 2'd0,
        CFG_TAG_SECOND = 2'd1,
        CFG_MAX_LEN    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] tag_first;
        logic [BYTE_W-1:0] tag_second;
        logic [WORD_W-1:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] byte_index;
        logic [WORD_W-1:0] packet_number;
        logic [WORD_W-1:0] payload_length;
        logic [WORD_W-1:0] received_crc;
        logic              last;
    } res_t;

endpackage

FILE: src/tlfr_parser.sv
// ============================================================================
// tlfr_parser
// Frame state machine: tag hunt, header, payload and CRC, one byte per load,
// with the result register.
// ============================================================================
module tlfr_parser
    import tlfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [BYTE_W-1:0] byte_in,
    input  cfg_t              cfg,
    input  logic              res_ready,
    output logic              res_valid,
    output res_t              res
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_PACKET  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              first_seen_reg, first_seen_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic              sub_reg, sub_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] pkt_reg, pkt_next;
    logic [WORD_W-1:0] len_reg, len_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;
    logic              hit;

    logic [WORD_W-1:0] word;
    logic [WORD_W:0]   count_inc;

    assign word      = {held_reg, byte_in};
    assign count_inc = {1'b0, count_reg} + {{WORD_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next      = phase_reg;
        first_seen_next = first_seen_reg;
        held_next       = held_reg;
        sub_next        = sub_reg;
        count_next      = count_reg;
        pkt_next        = pkt_reg;
        len_next        = len_reg;
        hit             = 1'b0;
        res_next        = '0;
        res_next.packet_number  = pkt_reg;
        res_next.payload_length = len_reg;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (byte_in == cfg.tag_first)
                begin
                    first_seen_next = 1'b1;
                end
                else if (first_seen_reg && byte_in == cfg.tag_second)
                begin
                    first_seen_next = 1'b0;
                    sub_next        = 1'b0;
                    phase_next      = PH_PACKET;
                end
                else
                begin
                    first_seen_next = 1'b0;
                end
            end
            PH_PACKET, PH_LENGTH:
            begin
                if (!sub_reg)
                begin
                    held_next = byte_in;
                    sub_next  = 1'b1;
                end
                else
                begin
                    sub_next = 1'b0;
                    if (phase_reg == PH_PACKET)
                    begin
                        pkt_next   = word;
                        phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        len_next = word;
                        if (word == '0 || word > cfg.max_payload_len)
                        begin
                            phase_next      = PH_HUNT;
                            first_seen_next = 1'b0;
                            count_next      = '0;
                        end
                        else
                        begin
                            count_next = '0;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                hit                = 1'b1;
                res_next.data_byte = byte_in;
                res_next.byte_index = count_reg;
                count_next         = count_inc[WORD_W-1:0];
                if (count_inc >= {1'b0, len_reg})
                begin
                    sub_next   = 1'b0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (!sub_reg)
                begin
                    held_next = byte_in;
                    sub_next  = 1'b1;
                end
                else
                begin
                    hit                   = 1'b1;
                    res_next.kind         = 1'b1;
                    res_next.received_crc = word;
                    res_next.last         = 1'b1;
                    phase_next            = PH_HUNT;
                    first_seen_next       = 1'b0;
                    sub_next              = 1'b0;
                    count_next            = '0;
                end
            end
            default:
            begin
                phase_next      = PH_HUNT;
                first_seen_next = 1'b0;
                sub_next        = 1'b0;
                count_next      = '0;
            end
        endcase

        if (load)
        begin
            res_valid_next = hit;
        end
        else
        begin
            res_valid_next = res_valid_reg && !res_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            first_seen_reg <= 1'b0;
            held_reg       <= '0;
            sub_reg        <= 1'b0;
            count_reg      <= '0;
            pkt_reg        <= '0;
            len_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (load)
            begin
                phase_reg      <= phase_next;
                first_seen_reg <= first_seen_next;
                held_reg       <= held_next;
                sub_reg        <= sub_next;
                count_reg      <= count_next;
                pkt_reg        <= pkt_next;
                len_reg        <= len_next;
                if (hit)
                begin
                    res_reg <= res_next;
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTH
    a_payload_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.kind |-> res_reg.byte_index < res_reg.payload_length)
        else $error("payload index beyond frame length");

    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < len_reg)
        else $error("payload count reached length inside payload phase");

    a_len_legal_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> len_reg != '0)
        else $error("zero length frame entered payload");
`endif

endmodule

FILE: src/tagged_length_frame_receiver_top.sv
// ============================================================================
// tagged_length_frame_receiver_top
// Byte-stream frame receiver: tag hunt, header, payload beats and
// frame-complete beat with header fields and received CRC.
// ============================================================================
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid/in_ready   | rx_byte
//  out     | output    | out_valid/out_ready | kind, data_byte, byte_index,
//          |           |                     | packet_number, payload_length,
//          |           |                     | received_crc, last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; the path runs
// through the input register, then the state update into the result register.
// Reset clears the frame state and loads the default tag and length limit.
// A stalled output holds its beat; the input register keeps taking a beat
// as long as the result register is free or being drained.
// cfg_ready is always high.
// ============================================================================
module tagged_length_frame_receiver_top
    import tlfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic [BYTE_W-1:0]    data_byte,
    output logic [WORD_W-1:0]    byte_index,
    output logic [WORD_W-1:0]    packet_number,
    output logic [WORD_W-1:0]    payload_length,
    output logic [WORD_W-1:0]    received_crc,
    output logic                 last,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              res_valid;
    res_t              res;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!res_valid || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tag_first       <= TAG_FIRST_RST;
            cfg_reg.tag_second      <= TAG_SECOND_RST;
            cfg_reg.max_payload_len <= MAX_LEN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TAG_FIRST:  cfg_reg.tag_first       <= cfg_data[BYTE_W-1:0];
                CFG_TAG_SECOND: cfg_reg.tag_second      <= cfg_data[BYTE_W-1:0];
                CFG_MAX_LEN:    cfg_reg.max_payload_len <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
            if (in_valid)
            begin
                in_byte_reg <= rx_byte;
            end
        end
    end

    tlfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .byte_in   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_ready (out_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid      = res_valid;
    assign kind           = res.kind;
    assign data_byte      = res.data_byte;
    assign byte_index     = res.byte_index;
    assign packet_number  = res.packet_number;
    assign payload_length = res.payload_length;
    assign received_crc   = res.received_crc;
    assign last           = res.last;

`ifndef SYNTH
    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == last)
        else $error("last and kind disagree");

    a_end_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> data_byte == '0 && byte_index == '0)
        else $error("frame end carries payload fields");

    a_payload_crc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> received_crc == '0)
        else $error("payload beat carries crc");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
`endif

endmodule

FILE: sim/tagged_length_frame_receiver_top_tb.sv
// ============================================================================
// tagged_length_frame_receiver_top_tb
// Self-checking bench for the tagged length frame receiver. Bytes are driven
// in random bursts and fed to an in-bench frame parser that queues the
// expected payload and frame-end beats. Each output beat is checked field by
// field against the queue while the output side stalls on its own pattern.
// ============================================================================
module tagged_length_frame_receiver_top_tb
    import tlfr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_PACKET  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } rx_phase_t;

    typedef enum int unsigned {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TOGGLE
    } ready_mode_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [WORD_W-1:0]    byte_index;
    logic [WORD_W-1:0]    packet_number;
    logic [WORD_W-1:0]    payload_length;
    logic [WORD_W-1:0]    received_crc;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    tagged_length_frame_receiver_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .packet_number  (packet_number),
        .payload_length (payload_length),
        .received_crc   (received_crc),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser state mirrored in the bench
    cfg_t              cur_cfg = '{TAG_FIRST_RST, TAG_SECOND_RST, MAX_LEN_RST};
    rx_phase_t         rx_phase = PH_HUNT;
    logic              armed = 1'b0;
    logic              half = 1'b0;
    logic [BYTE_W-1:0] held = '0;
    logic [WORD_W-1:0] pay_count = '0;
    logic [WORD_W-1:0] hdr_packet = '0;
    logic [WORD_W-1:0] hdr_length = '0;

    res_t        expected_results[$];
    int unsigned mismatches = 0;
    int unsigned sent_bytes = 0;
    int unsigned burst_left = 0;
    bit          pace_on = 1'b1;
    int unsigned hold_len = 0;

    function automatic void back_to_hunt();
        rx_phase  = PH_HUNT;
        armed     = 1'b0;
        half      = 1'b0;
        pay_count = '0;
    endfunction

    function automatic bit parse_rx_byte(input logic [BYTE_W-1:0] b, output res_t r);
        logic [WORD_W-1:0] word;
        r = '0;
        word = {held, b};
        parse_rx_byte = 1'b0;
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == cur_cfg.tag_first)
                    armed = 1'b1;
                else if (armed && b == cur_cfg.tag_second)
                begin
                    armed = 1'b0;
                    half = 1'b0;
                    rx_phase = PH_PACKET;
                end
                else
                    armed = 1'b0;
            end
            PH_PACKET, PH_LENGTH:
            begin
                if (!half)
                begin
                    held = b;
                    half = 1'b1;
                end
                else
                begin
                    half = 1'b0;
                    if (rx_phase == PH_PACKET)
                    begin
                        hdr_packet = word;
                        rx_phase = PH_LENGTH;
                    end
                    else
                    begin
                        hdr_length = word;
                        if (word == '0 || word > cur_cfg.max_payload_len)
                            back_to_hunt();
                        else
                        begin
                            pay_count = '0;
                            rx_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                r.data_byte = b;
                r.byte_index = pay_count;
                r.packet_number = hdr_packet;
                r.payload_length = hdr_length;
                parse_rx_byte = 1'b1;
                pay_count = pay_count + 16'd1;
                if (pay_count >= hdr_length)
                begin
                    half = 1'b0;
                    rx_phase = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (!half)
                begin
                    held = b;
                    half = 1'b1;
                end
                else
                begin
                    r.kind = 1'b1;
                    r.packet_number = hdr_packet;
                    r.payload_length = hdr_length;
                    r.received_crc = word;
                    r.last = 1'b1;
                    parse_rx_byte = 1'b1;
                    back_to_hunt();
                end
            end
            default:
                back_to_hunt();
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        res_t r;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_bytes++;
        if (parse_rx_byte(b, r))
            expected_results.push_back(r);
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    // fill_byte < 0 gives random payload
    task automatic send_frame(input logic [WORD_W-1:0] pkt, input logic [WORD_W-1:0] len,
                              input logic [WORD_W-1:0] crc, input int fill_byte);
        send_byte(cur_cfg.tag_first);
        send_byte(cur_cfg.tag_second);
        send_byte(pkt[15:8]);
        send_byte(pkt[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len != '0 && len <= cur_cfg.max_payload_len)
        begin
            for (int i = 0; i < int'(len); i++)
                send_byte(fill_byte < 0 ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(fill_byte));
            send_byte(crc[15:8]);
            send_byte(crc[7:0]);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TAG_FIRST:  cur_cfg.tag_first = data[BYTE_W-1:0];
            CFG_TAG_SECOND: cur_cfg.tag_second = data[BYTE_W-1:0];
            CFG_MAX_LEN:    cur_cfg.max_payload_len = data;
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // output side stall pattern, plus long hold-offs on request
    initial
    begin : ready_gen
        ready_mode_t mode;
        int unsigned left;
        mode = RDY_ALWAYS;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            if (left == 0)
            begin
                mode = ready_mode_t'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                RDY_ALWAYS: out_ready <= 1'b1;
                RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:    out_ready <= ~out_ready;
            endcase
        end
    end

    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected output beat");
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (kind !== exp_r.kind)
                begin
                    $error("kind exp %0d got %0d", exp_r.kind, kind);
                    mismatches++;
                end
                if (data_byte !== exp_r.data_byte)
                begin
                    $error("data_byte exp %0h got %0h", exp_r.data_byte, data_byte);
                    mismatches++;
                end
                if (byte_index !== exp_r.byte_index)
                begin
                    $error("byte_index exp %0d got %0d", exp_r.byte_index, byte_index);
                    mismatches++;
                end
                if (packet_number !== exp_r.packet_number)
                begin
                    $error("packet_number exp %0h got %0h", exp_r.packet_number,
                           packet_number);
                    mismatches++;
                end
                if (payload_length !== exp_r.payload_length)
                begin
                    $error("payload_length exp %0d got %0d", exp_r.payload_length,
                           payload_length);
                    mismatches++;
                end
                if (received_crc !== exp_r.received_crc)
                begin
                    $error("received_crc exp %0h got %0h", exp_r.received_crc, received_crc);
                    mismatches++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last exp %0d got %0d", exp_r.last, last);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_tag_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(TAG_SECOND_RST);
        // first tag, foreign byte, second tag: disarmed
        send_byte(TAG_FIRST_RST);
        send_byte(8'h41);
        send_byte(TAG_SECOND_RST);
        // repeated first tag still arms
        send_byte(TAG_FIRST_RST);
        send_frame(16'hFFFF, 16'd1, 16'hFFFF, 8'hFF);
        // a lone second tag after a frame starts nothing
        send_byte(TAG_SECOND_RST);
        send_frame(16'h0000, 16'd2, 16'h0000, 8'h00);
        wait_idle();
    endtask

    task automatic test_length_limits();
        send_frame(16'h1234, 16'd0, 16'h0, -1);
        send_frame(16'h5678, MAX_LEN_RST + 16'd1, 16'h0, -1);
        send_frame(16'hA5C3, 16'd3, 16'h8001, -1);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_TAG_FIRST, 16'hFF00);
        write_reg(CFG_TAG_SECOND, 16'h00FF);
        write_reg(CFG_MAX_LEN, 16'd1);
        send_frame(16'h0102, 16'd1, 16'hBEEF, -1);
        send_frame(16'h0304, 16'd2, 16'h0, -1);
        send_frame(16'h0506, 16'd1, 16'h7FFE, -1);
        wait_idle();
        write_reg(CFG_TAG_FIRST, 16'h00FF);
        write_reg(CFG_TAG_SECOND, 16'hFF00);
        write_reg(CFG_MAX_LEN, 16'hFFFF);
        send_frame(16'hC0DE, 16'd300, 16'h1357, -1);
        wait_idle();
        // equal tags never open a frame
        write_reg(CFG_TAG_FIRST, 16'h0055);
        write_reg(CFG_TAG_SECOND, 16'h0055);
        repeat (4) send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h99);
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_TAG_FIRST, {8'h00, TAG_FIRST_RST});
        write_reg(CFG_TAG_SECOND, {8'h00, TAG_SECOND_RST});
        write_reg(CFG_MAX_LEN, MAX_LEN_RST);
        send_frame(16'h4242, 16'd4, 16'h2424, -1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        pace_on = 1'b0;
        hold_len = 300;
        send_frame(16'h7777, 16'd40, 16'h8888, -1);
        send_frame(16'h7778, 16'd5, 16'h8889, -1);
        pace_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned cap;
        int unsigned max_len;
        logic [BYTE_W-1:0] t1;
        logic [BYTE_W-1:0] t2;
        if ($urandom_range(0, 1))
        begin
            t1 = TAG_FIRST_RST;
            t2 = TAG_SECOND_RST;
        end
        else
        begin
            t1 = 8'($urandom_range(0, 255));
            t2 = t1 + 8'($urandom_range(1, 255));
        end
        write_reg(CFG_TAG_FIRST, {8'($urandom_range(0, 255)), t1});
        write_reg(CFG_TAG_SECOND, {8'($urandom_range(0, 255)), t2});
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_MAX_LEN, 16'd1);
            1:       write_reg(CFG_MAX_LEN, 16'($urandom_range(2, 64)));
            2:       write_reg(CFG_MAX_LEN, MAX_LEN_RST);
            default: write_reg(CFG_MAX_LEN, 16'hFFFF);
        endcase
        pace_on = ($urandom_range(0, 3) != 0);
        max_len = 32'(cur_cfg.max_payload_len);
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                cap = ($urandom_range(0, 7) == 0) ? 80 : 20;
                if (cap > max_len)
                    cap = max_len;
                send_frame(16'($urandom), 16'($urandom_range(1, cap)), 16'($urandom), -1);
            end
            else if (pick == 7)
            begin
                if (max_len == 16'hFFFF || $urandom_range(0, 1))
                    send_frame(16'($urandom), 16'd0, 16'h0, -1);
                else
                    send_frame(16'($urandom), 16'($urandom_range(max_len + 1, 65535)),
                               16'h0, -1);
            end
            else if (pick == 8)
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(cur_cfg.tag_first);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_tag_hunt();
        test_length_limits();
        test_config_extremes();
        test_backpressure();
        repeat (4) test_random_traffic(170);
        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
